### src/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared codes, constants and result type for the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // Access kinds carried on the input word's tuser
    localparam logic [1:0] FUNC_CPU_RD = 2'd0;
    localparam logic [1:0] FUNC_CPU_WR = 2'd1;
    localparam logic [1:0] FUNC_PPU    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Target memory codes
    localparam logic [2:0] TGT_NONE = 3'd0;
    localparam logic [2:0] TGT_REG  = 3'd1;
    localparam logic [2:0] TGT_WRAM = 3'd2;
    localparam logic [2:0] TGT_PRG  = 3'd3;
    localparam logic [2:0] TGT_CHR  = 3'd4;
    localparam logic [2:0] TGT_NT   = 3'd5;

    // Register sub-selects, addr[10:8]
    localparam logic [2:0] SUB_BANK    = 3'd0;
    localparam logic [2:0] SUB_MODE    = 3'd2;
    localparam logic [2:0] SUB_ID      = 3'd3;
    localparam logic [2:0] SUB_ZERO    = 3'd6;

    // Bytes driven on register reads
    localparam logic [7:0] ID_BYTE   = 8'h8F;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Mode register bits
    localparam int MODE_HMIRROR = 0;
    localparam int MODE_LATCH   = 1;
    localparam int MODE_PRG32K  = 2;

    localparam int MAP_W = 23;

    typedef struct packed {
        logic [7:0]       read_data;
        logic             read_driven;
        logic [2:0]       target;
        logic [MAP_W-1:0] mapped_addr;
    } cbm_result_t;

endpackage

### src/cbm_core.sv
// ----------------------------------------------------------------------------
// cbm_core
// Bank/mode registers, PPU pattern latch and the single-pass address decode.
// ----------------------------------------------------------------------------
module cbm_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [1:0]           func,
    input  logic [15:0]          addr,
    input  logic [7:0]           data,
    output cbm_pkg::cbm_result_t result
);
    import cbm_pkg::*;

    logic [7:0]  bank_reg;
    logic [7:0]  bank_next;
    logic [7:0]  mode_reg;
    logic [7:0]  mode_next;
    logic        latch_reg;
    logic        latch_next;

    logic [2:0]       cpu_tgt;
    logic [MAP_W-1:0] cpu_ma;
    logic [13:0]      p;
    logic             nt_snoop;
    logic             chr_bank;
    logic             nt_page;
    logic [2:0]       sub;

    assign sub = addr[10:8];
    assign p   = addr[13:0];

    // CPU address decode
    always_comb
    begin
        cpu_tgt = TGT_NONE;
        cpu_ma  = '0;
        if (addr[15])
        begin
            cpu_tgt = TGT_PRG;
            if (mode_reg[MODE_PRG32K])
                cpu_ma = {bank_reg, addr[14:0]};
            else if (addr[14])
                cpu_ma = {9'd0, addr[13:0]};
            else
                cpu_ma = {1'b0, bank_reg, addr[13:0]};
        end
        else if (addr[14:13] == 2'b11)
        begin
            cpu_tgt = TGT_WRAM;
            cpu_ma  = {10'd0, addr[12:0]};
        end
        else if (addr[14:12] == 3'b101)
        begin
            cpu_tgt = TGT_REG;
        end
    end

    // Nametable snoop below the attribute area, page pick by mirroring
    assign nt_snoop = p[13] && (p[9:6] != 4'hF);
    assign nt_page  = mode_reg[MODE_HMIRROR] ? p[11] : p[10];
    assign chr_bank = p[12] ? 1'b1 : (mode_reg[MODE_LATCH] & latch_reg);

    // Result and next state
    always_comb
    begin
        result     = '0;
        bank_next  = bank_reg;
        mode_next  = mode_reg;
        latch_next = latch_reg;
        unique case (func)
            FUNC_CPU_RD:
            begin
                result.target      = cpu_tgt;
                result.mapped_addr = cpu_ma;
                if (cpu_tgt == TGT_REG)
                begin
                    if (sub == SUB_ID)
                    begin
                        result.read_data   = ID_BYTE;
                        result.read_driven = 1'b1;
                    end
                    else if (sub == SUB_ZERO)
                    begin
                        result.read_data   = ZERO_BYTE;
                        result.read_driven = 1'b1;
                    end
                end
            end
            FUNC_CPU_WR:
            begin
                result.target      = cpu_tgt;
                result.mapped_addr = cpu_ma;
                if (cpu_tgt == TGT_REG)
                begin
                    if (sub == SUB_BANK)
                        bank_next = data;
                    else if (sub == SUB_MODE)
                        mode_next = data;
                end
            end
            FUNC_PPU:
            begin
                if (nt_snoop)
                    latch_next = nt_page;
                if (!p[13])
                begin
                    result.target      = TGT_CHR;
                    result.mapped_addr = {10'd0, chr_bank, p[11:0]};
                end
                else if (p[13:8] != 6'h3F)
                begin
                    result.target      = TGT_NT;
                    result.mapped_addr = {12'd0, nt_page, p[9:0]};
                end
            end
            FUNC_UNUSED:
            begin
                result = '0;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Commit state as the word leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= '0;
            mode_reg  <= '0;
            latch_reg <= 1'b0;
        end
        else if (en)
        begin
            bank_reg  <= bank_next;
            mode_reg  <= mode_next;
            latch_reg <= latch_next;
        end
    end

endmodule

### src/cartridge_bank_mapper_with_ppu_latch_top.sv
// Path: an accepted word passes the input register, then the result register, to the output.
// Throughput: one word per cycle unless m_tready stalls; both registers advance together.
// Result register holds a finished word while a new word is taken into the input register.
// Reset (rst_n low, asynchronous) clears both valid flags, bank, mode and pattern latch.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_ppu_latch_top
// Cartridge mapper: decodes CPU/PPU bus words to target memory and address.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_ppu_latch_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // addr[15:0], data[23:16]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[7:0], read_driven[8], mapped_addr[31:9]
    output logic [2:0]  m_tuser    // target[2:0]
);
    import cbm_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  func_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic        out_valid_reg;
    cbm_result_t out_reg;
    cbm_result_t result;
    logic        advance;
    logic        in_fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    cbm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (in_valid_reg && advance),
        .func   (func_reg),
        .addr   (addr_reg),
        .data   (data_reg),
        .result (result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= s_tuser;
            addr_reg <= s_tdata[15:0];
            data_reg <= s_tdata[23:16];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.mapped_addr, out_reg.read_driven, out_reg.read_data};
    assign m_tuser  = out_reg.target;

`ifndef NO_ASSERTIONS
    // A driven read byte only comes from the register window
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> m_tuser == TGT_REG)
        else $error("read_driven outside register target");

    // No mapped address for none or register targets
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == TGT_NONE || m_tuser == TGT_REG) |-> m_tdata[31:9] == '0)
        else $error("mapped address set for unmapped target");

    // A word leaving the input register lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance |=> out_valid_reg)
        else $error("word lost between stages");

    // An accepted word is held in the input register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_valid_reg && addr_reg == $past(s_tdata[15:0]))
        else $error("accepted word not captured");
`endif

endmodule
